/* sv/lwoi_pkg.sv */
// Shared constants, codes and types for the linear window offset index.
package lwoi_pkg;

  // Field widths fixed by the interface
  localparam int OP_W       = 2;
  localparam int START_W    = 29;
  localparam int STOP_W     = 30;
  localparam int OFFSET_W   = 64;
  localparam int RWIN_W     = 15;
  localparam int OUT_WIN_W  = 15;
  localparam int USED_W     = 16;

  // Default geometry: 16 kb windows over a 2^29 coordinate space
  localparam int WINDOW_SHIFT_DEF = 14;
  localparam int WINDOW_COUNT_DEF = 32768;

  // Largest legal exclusive stop coordinate
  localparam logic [STOP_W-1:0] COORD_LIMIT = STOP_W'(1) << START_W;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 2'd0,
    OP_FINALIZE = 2'd1,
    OP_READ     = 2'd2,
    OP_NOP      = 2'd3
  } op_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INS,
    ST_FIN,
    ST_RD,
    ST_DONE
  } state_t;

endpackage

/* sv/linear_window_offset_index_unit.sv */
// Top level: sequencer, result register and window store of the linear index.
//
// Usage: one transaction on the in_ channel carries an operation (insert,
// finalize, read or no-op) with its operands; each one produces exactly one
// transaction on the out_ channel, in order. Both channels use valid/ready.
// An insert walks the windows it covers, a finalize walks the used windows
// when more than one is used, and a read does one store read when its window
// is in range; a rejected insert or a no-op goes straight to the result.
// The store has a single read port: each window visited costs one read,
// issued back to back with the write of the previous window.
// in_ready rises again as the result enters the output register.
// After reset the store is swept to zero, one window per cycle, over all
// WINDOW_COUNT windows; in_ready stays low during that sweep.
// When the receiver stalls, the finished result waits in the output register
// and the block may take and work on one more transaction; it then holds it
// complete until the output register frees.
module linear_window_offset_index_unit import lwoi_pkg::*; #(
  parameter int WINDOW_SHIFT = WINDOW_SHIFT_DEF,
  parameter int WINDOW_COUNT = WINDOW_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OP_W-1:0]      in_operation,
  input  logic [START_W-1:0]   in_start_pos,
  input  logic [STOP_W-1:0]    in_stop_pos,
  input  logic [OFFSET_W-1:0]  in_file_offset,
  input  logic [RWIN_W-1:0]    in_read_window,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_WIN_W-1:0] out_first_window,
  output logic [OUT_WIN_W-1:0] out_last_window,
  output logic [OFFSET_W-1:0]  out_read_offset,
  output logic [USED_W-1:0]    out_used_windows,
  output logic                 out_bad_interval
);

  localparam int AW = $clog2(WINDOW_COUNT);
  localparam int CW = $clog2(WINDOW_COUNT + 1);

  // Sequencer and loop state
  state_t              state_r, state_nxt;
  logic [CW-1:0]       addr_r, addr_nxt;
  logic [CW-1:0]       end_r, end_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [OFFSET_W-1:0] offset_r, offset_nxt;
  logic [OFFSET_W-1:0] prev_r, prev_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [CW-1:0]       rd_addr_r, rd_addr_nxt;
  logic                rd_ok_r, rd_ok_nxt;

  // Staged result of the current transaction
  logic [OUT_WIN_W-1:0] res_first_r, res_first_nxt;
  logic [OUT_WIN_W-1:0] res_last_r, res_last_nxt;
  logic [OFFSET_W-1:0]  res_data_r, res_data_nxt;
  logic                 res_bad_r, res_bad_nxt;

  // Output register
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_WIN_W-1:0] out_first_r, out_first_nxt;
  logic [OUT_WIN_W-1:0] out_last_r, out_last_nxt;
  logic [OFFSET_W-1:0]  out_data_r, out_data_nxt;
  logic [USED_W-1:0]    out_used_r, out_used_nxt;
  logic                 out_bad_r, out_bad_nxt;

  // Store ports
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [OFFSET_W-1:0] mem_wdata, mem_rdata;

  // Interval decode
  logic [START_W-1:0] lo_full;
  logic [STOP_W-1:0]  stop_m1;
  logic [STOP_W-1:0]  hi_full;
  logic               bad_ivl;
  logic [CW-1:0]      lo_idx, hi_idx, hi_p1;
  logic               rd_in_range;
  logic               loop_issue;

  always_comb begin
    lo_full     = in_start_pos >> WINDOW_SHIFT;
    stop_m1     = in_stop_pos - STOP_W'(1);
    hi_full     = stop_m1 >> WINDOW_SHIFT;
    bad_ivl     = ({1'b0, in_start_pos} >= in_stop_pos) || (in_stop_pos > COORD_LIMIT) ||
                  ({2'b0, hi_full} >= 32'(WINDOW_COUNT));
    lo_idx      = CW'(lo_full);
    hi_idx      = CW'(hi_full);
    hi_p1       = hi_idx + CW'(1);
    rd_in_range = ({17'b0, in_read_window} < 32'(WINDOW_COUNT));
    loop_issue  = (addr_r <= end_r);
  end

  lwoi_mem #(
    .DEPTH (WINDOW_COUNT),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      addr_r      <= '0;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    end_r       <= end_nxt;
    offset_r    <= offset_nxt;
    prev_r      <= prev_nxt;
    rd_addr_r   <= rd_addr_nxt;
    rd_ok_r     <= rd_ok_nxt;
    res_first_r <= res_first_nxt;
    res_last_r  <= res_last_nxt;
    res_data_r  <= res_data_nxt;
    res_bad_r   <= res_bad_nxt;
    out_first_r <= out_first_nxt;
    out_last_r  <= out_last_nxt;
    out_data_r  <= out_data_nxt;
    out_used_r  <= out_used_nxt;
    out_bad_r   <= out_bad_nxt;
  end

  // Next state, store accesses and results
  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    end_nxt       = end_r;
    cnt_nxt       = cnt_r;
    offset_nxt    = offset_r;
    prev_nxt      = prev_r;
    rd_vld_nxt    = 1'b0;
    rd_addr_nxt   = rd_addr_r;
    rd_ok_nxt     = rd_ok_r;
    res_first_nxt = res_first_r;
    res_last_nxt  = res_last_r;
    res_data_nxt  = res_data_r;
    res_bad_nxt   = res_bad_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_first_nxt = out_first_r;
    out_last_nxt  = out_last_r;
    out_data_nxt  = out_data_r;
    out_used_nxt  = out_used_r;
    out_bad_nxt   = out_bad_r;
    in_ready      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = addr_r[AW-1:0];
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = addr_r[AW-1:0];

    unique case (state_r)
      // Sweep the store to zero after reset
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (addr_r == CW'(WINDOW_COUNT - 1)) begin
          addr_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          addr_nxt = addr_r + CW'(1);
        end
      end

      // Take a transaction and set up its loop
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          res_first_nxt = '0;
          res_last_nxt  = '0;
          res_data_nxt  = '0;
          res_bad_nxt   = 1'b0;
          case (op_t'(in_operation))
            OP_INSERT: begin
              if (bad_ivl) begin
                res_bad_nxt = 1'b1;
                state_nxt   = ST_DONE;
              end else begin
                res_first_nxt = OUT_WIN_W'(lo_full);
                res_last_nxt  = OUT_WIN_W'(hi_full);
                offset_nxt    = in_file_offset;
                addr_nxt      = lo_idx;
                end_nxt       = hi_idx;
                if (cnt_r < hi_p1) begin
                  cnt_nxt = hi_p1;
                end
                state_nxt = ST_INS;
              end
            end
            OP_FINALIZE: begin
              if (cnt_r > CW'(1)) begin
                addr_nxt  = '0;
                end_nxt   = cnt_r - CW'(1);
                state_nxt = ST_FIN;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            OP_READ: begin
              mem_re    = rd_in_range;
              mem_raddr = AW'(in_read_window);
              rd_ok_nxt = rd_in_range;
              state_nxt = ST_RD;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      // Walk windows: read one, update the one read last cycle
      ST_INS, ST_FIN: begin
        if (loop_issue) begin
          mem_re   = 1'b1;
          addr_nxt = addr_r + CW'(1);
        end
        rd_vld_nxt  = loop_issue;
        rd_addr_nxt = addr_r;
        if (rd_vld_r) begin
          mem_waddr = rd_addr_r[AW-1:0];
          if (state_r == ST_INS) begin
            mem_we    = (mem_rdata == '0);
            mem_wdata = offset_r;
          end else if (rd_addr_r == '0) begin
            prev_nxt = mem_rdata;
          end else if (mem_rdata == '0) begin
            mem_we    = 1'b1;
            mem_wdata = prev_r;
          end else begin
            prev_nxt = mem_rdata;
          end
        end
        if (!loop_issue) begin
          state_nxt = ST_DONE;
        end
      end

      // Capture read data
      ST_RD: begin
        res_data_nxt = rd_ok_r ? mem_rdata : '0;
        state_nxt    = ST_DONE;
      end

      // Hand the result to the output register once it frees
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_first_nxt = res_first_r;
          out_last_nxt  = res_last_r;
          out_data_nxt  = res_data_r;
          out_used_nxt  = USED_W'(cnt_r);
          out_bad_nxt   = res_bad_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_first_window = out_first_r;
  assign out_last_window  = out_last_r;
  assign out_read_offset  = out_data_r;
  assign out_used_windows = out_used_r;
  assign out_bad_interval = out_bad_r;

  // Read and write never hit the same window in one cycle, so no forwarding
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("store read and write collide on one window");

  // The used-window count never shrinks
  a_cnt_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (cnt_r >= $past(cnt_r)))
    else $error("used-window count decreased");

  // A rejected insert reports no windows
  a_bad_no_windows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_interval) |-> (out_first_window == '0 && out_last_window == '0))
    else $error("rejected insert reports windows");

  // Store writes come only from the sweep or a window walk
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_CLEAR || state_r == ST_INS || state_r == ST_FIN))
    else $error("store written outside sweep or walk");

  // No transaction is taken during the clearing sweep
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_ready)
    else $error("transaction taken during clearing sweep");

endmodule

/* sv/lwoi_mem.sv */
// Window offset store: one write port, one read port, registered read data.
module lwoi_mem import lwoi_pkg::*; #(
  parameter int DEPTH = WINDOW_COUNT_DEF,
  parameter int AW    = $clog2(WINDOW_COUNT_DEF)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  logic [OFFSET_W-1:0] wdata,
  input  logic                re,
  input  logic [AW-1:0]       raddr,
  output logic [OFFSET_W-1:0] rdata
);

  logic [OFFSET_W-1:0] mem [DEPTH];
  logic [OFFSET_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered output
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* test/tb.sv */
// Testbench for the linear window offset index: directed and random transactions checked by a scoreboard.
module tb;
  import lwoi_pkg::*;

  localparam int WIN_SHIFT    = WINDOW_SHIFT_DEF;
  localparam int WIN_SIZE     = 1 << WIN_SHIFT;
  localparam int N_WIN        = WINDOW_COUNT_DEF;
  localparam int RANDOM_ITEMS = 1900;

  typedef struct packed {
    logic [OUT_WIN_W-1:0] first_window;
    logic [OUT_WIN_W-1:0] last_window;
    logic [OFFSET_W-1:0]  read_offset;
    logic [USED_W-1:0]    used_windows;
    logic                 bad_interval;
  } index_result_t;

  // Window store shadow plus the queue of results still owed by the block
  class window_index_scoreboard;
    bit [OFFSET_W-1:0] offsets [N_WIN];
    int unsigned       used_count;
    index_result_t     expected_q[$];
    int unsigned       n_errors;
    int unsigned       n_checked;

    // Apply one accepted transaction to the shadow store and queue its result
    function void note_request(op_t op, logic [START_W-1:0] start_pos,
                               logic [STOP_W-1:0] stop_pos,
                               logic [OFFSET_W-1:0] file_offset,
                               logic [RWIN_W-1:0] read_window);
      index_result_t r;
      int unsigned   lo;
      int unsigned   hi;
      int unsigned   w;
      r = '0;
      case (op)
        OP_INSERT: begin
          if (start_pos >= stop_pos || stop_pos > COORD_LIMIT) begin
            r.bad_interval = 1'b1;
          end else begin
            lo = start_pos >> WIN_SHIFT;
            hi = (stop_pos - 1'b1) >> WIN_SHIFT;
            if (hi >= N_WIN) begin
              r.bad_interval = 1'b1;
            end else begin
              // Fill only windows that are still empty
              for (w = lo; w <= hi; w++)
                if (offsets[w] == '0) offsets[w] = file_offset;
              if (used_count < hi + 1) used_count = hi + 1;
              r.first_window = OUT_WIN_W'(lo);
              r.last_window  = OUT_WIN_W'(hi);
            end
          end
        end
        OP_FINALIZE: begin
          // Carry offsets forward into empty windows, ascending
          for (w = 1; w < used_count && w < N_WIN; w++)
            if (offsets[w] == '0) offsets[w] = offsets[w-1];
        end
        OP_READ: begin
          if (read_window < N_WIN) r.read_offset = offsets[read_window];
        end
        default: ;
      endcase
      r.used_windows = USED_W'(used_count);
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      n_errors++;
    endtask

    // Compare one result transaction with the oldest expectation
    task check_result(index_result_t got);
      index_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result transaction %h", got));
        return;
      end
      want = expected_q.pop_front();
      n_checked++;
      if (got.first_window !== want.first_window)
        report($sformatf("result %0d first_window %0d, expected %0d",
                         n_checked, got.first_window, want.first_window));
      if (got.last_window !== want.last_window)
        report($sformatf("result %0d last_window %0d, expected %0d",
                         n_checked, got.last_window, want.last_window));
      if (got.read_offset !== want.read_offset)
        report($sformatf("result %0d read_offset %h, expected %h",
                         n_checked, got.read_offset, want.read_offset));
      if (got.used_windows !== want.used_windows)
        report($sformatf("result %0d used_windows %0d, expected %0d",
                         n_checked, got.used_windows, want.used_windows));
      if (got.bad_interval !== want.bad_interval)
        report($sformatf("result %0d bad_interval %b, expected %b",
                         n_checked, got.bad_interval, want.bad_interval));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n          = 1'b0;
  logic                 in_valid       = 1'b0;
  logic                 in_ready;
  logic [OP_W-1:0]      in_operation   = '0;
  logic [START_W-1:0]   in_start_pos   = '0;
  logic [STOP_W-1:0]    in_stop_pos    = '0;
  logic [OFFSET_W-1:0]  in_file_offset = '0;
  logic [RWIN_W-1:0]    in_read_window = '0;
  logic                 out_valid;
  logic                 out_ready      = 1'b0;
  logic [OUT_WIN_W-1:0] out_first_window;
  logic [OUT_WIN_W-1:0] out_last_window;
  logic [OFFSET_W-1:0]  out_read_offset;
  logic [USED_W-1:0]    out_used_windows;
  logic                 out_bad_interval;

  // Set to turn off idling on both sides
  bit quiet = 1'b0;

  window_index_scoreboard sb = new;

  linear_window_offset_index_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_start_pos     (in_start_pos),
    .in_stop_pos      (in_stop_pos),
    .in_file_offset   (in_file_offset),
    .in_read_window   (in_read_window),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_first_window (out_first_window),
    .out_last_window  (out_last_window),
    .out_read_offset  (out_read_offset),
    .out_used_windows (out_used_windows),
    .out_bad_interval (out_bad_interval)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hold reset low from time zero, then release it once
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Abort a hung run
  initial begin
    #24000000;
    $display("*** FAILED ***");
    $finish;
  end

  // Check results first, then log the transaction taken at the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1 && out_ready)
        sb.check_result({out_first_window, out_last_window, out_read_offset,
                         out_used_windows, out_bad_interval});
      if (in_valid && in_ready === 1'b1)
        sb.note_request(op_t'(in_operation), in_start_pos, in_stop_pos,
                        in_file_offset, in_read_window);
    end
  end

  function automatic logic [OFFSET_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Offer one transaction, now and then after a random gap, and hold until taken
  task automatic send_item(op_t op, logic [START_W-1:0] start_pos,
                           logic [STOP_W-1:0] stop_pos,
                           logic [OFFSET_W-1:0] file_offset,
                           logic [RWIN_W-1:0] read_window);
    if (!quiet && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_start_pos   <= start_pos;
    in_stop_pos    <= stop_pos;
    in_file_offset <= file_offset;
    in_read_window <= read_window;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  task automatic insert(logic [START_W-1:0] start_pos, logic [STOP_W-1:0] stop_pos,
                        logic [OFFSET_W-1:0] file_offset);
    send_item(OP_INSERT, start_pos, stop_pos, file_offset, RWIN_W'($urandom));
  endtask

  task automatic read_at(logic [RWIN_W-1:0] read_window);
    send_item(OP_READ, START_W'($urandom), STOP_W'($urandom), rand64(), read_window);
  endtask

  task automatic finalize_all();
    send_item(OP_FINALIZE, START_W'($urandom), STOP_W'($urandom), rand64(),
              RWIN_W'($urandom));
  endtask

  // Well-formed insert, mostly in low windows and mostly no longer than two windows
  task automatic send_random_insert();
    int unsigned         win;
    int unsigned         span_len;
    int unsigned         pick;
    logic [START_W-1:0]  s;
    logic [STOP_W-1:0]   e;
    logic [OFFSET_W-1:0] off;
    win = ($urandom_range(99) < 70) ? $urandom_range(63) : $urandom_range(4095);
    s = START_W'(win * WIN_SIZE + $urandom_range(WIN_SIZE - 1));
    span_len = ($urandom_range(9) < 7) ? $urandom_range(1, 2 * WIN_SIZE)
                                       : $urandom_range(1, 8 * WIN_SIZE);
    e = STOP_W'(s) + STOP_W'(span_len);
    // Snap to window boundaries now and then
    if ($urandom_range(4) == 0) begin
      s[WIN_SHIFT-1:0] = '0;
      e = STOP_W'(s) + STOP_W'(WIN_SIZE * $urandom_range(1, 3));
    end
    pick = $urandom_range(99);
    if (pick < 5)      off = '0;
    else if (pick < 8) off = {OFFSET_W{1'b1}};
    else               off = rand64();
    insert(s, e, off);
  endtask

  // Rejected insert: empty interval or stop past the coordinate space
  task automatic send_bad_insert();
    logic [START_W-1:0] s;
    logic [STOP_W-1:0]  e;
    s = START_W'($urandom);
    if ($urandom_range(1))
      e = STOP_W'(s) - STOP_W'($urandom_range(s));
    else
      e = COORD_LIMIT + 1'b1 + STOP_W'($urandom_range(32'h1FFF_FFFE));
    insert(s, e, rand64());
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
  endtask

  // Result side: random back-pressure, plus one long hold-off mid-run
  initial begin
    bit held;
    held = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!held && sb.n_checked >= 900) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 28);
      end
      @(posedge clk);
    end
  end

  // Stimulus
  initial begin
    int          i;
    int unsigned pick;
    int unsigned hi_win;
    wait (rst_n === 1'b1);
    @(posedge clk);

    // Empty store, no-op, zero offset and the first-writer-wins rule
    read_at('0);
    send_item(OP_NOP, '1, '1, '1, '1);
    insert(0, 1, '0);
    read_at(0);
    insert(0, 1, 64'h0000_0000_0001_0000);
    insert(0, STOP_W'(WIN_SIZE), 64'h1111_2222_3333_4444);
    insert(START_W'(WIN_SIZE - 1), STOP_W'(WIN_SIZE + 1), 64'h2222_0000_0000_0002);
    // Rejects: empty, reversed, and past the coordinate limit
    insert(100, 100, rand64());
    insert('1, '0, rand64());
    insert(0, COORD_LIMIT + STOP_W'(1), rand64());
    insert('1, '1, '1);
    // Gap of empty windows, reads inside and beyond the used count, then fill
    insert(START_W'(5 * WIN_SIZE), STOP_W'(5 * WIN_SIZE + 1), '1);
    read_at(3);
    read_at('1);
    finalize_all();
    read_at(3);
    read_at(5);
    insert(START_W'(6 * WIN_SIZE), STOP_W'(9 * WIN_SIZE), 64'hDEAD_BEEF_0000_0001);
    read_at(8);
    finalize_all();
    read_at(7);
    send_item(OP_NOP, '0, '0, '0, '0);

    // Random mix of transactions
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = (i >= 200 && i < 500);
      if (i == 1400) wait_drained();
      pick = $urandom_range(99);
      if (pick < 2) begin
        finalize_all();
      end else if (pick < 5) begin
        send_item(OP_NOP, START_W'($urandom), STOP_W'($urandom), rand64(),
                  RWIN_W'($urandom));
      end else if (pick < 15) begin
        send_bad_insert();
      end else if (pick < 45) begin
        hi_win = (sb.used_count + 8 < N_WIN) ? sb.used_count + 8 : N_WIN - 1;
        if ($urandom_range(4) == 0) read_at(RWIN_W'($urandom));
        else                        read_at(RWIN_W'($urandom_range(hi_win)));
      end else begin
        send_random_insert();
      end
    end
    quiet = 1'b0;

    // Largest coordinates: top window, full span, fill, reads at the top
    insert(START_W'(N_WIN * WIN_SIZE - 1), COORD_LIMIT, 64'h8000_0000_0000_0001);
    read_at(20000);
    insert(0, COORD_LIMIT, 64'h0123_4567_89AB_CDEF);
    read_at(20000);
    finalize_all();
    read_at('1);
    read_at(RWIN_W'(N_WIN - 2));

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.n_errors == 0 && sb.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
